// ===== design/nps_pkg.sv =====
// Shared types, widths and codes of the non-preemptive priority scheduler.
`timescale 1ns / 1ps
package nps_pkg;

  // Default number of process entries held by the entry memory.
  localparam int unsigned MAX_PROCS_DEF = 16;

  // Field widths of the stream items.
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned PNUM_W = 7;
  localparam int unsigned CLK_W  = 23;
  localparam int unsigned SUM_W  = 29;

  // Packed stream data widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 2 * TIME_W + PRIO_W;
  localparam int unsigned OUT_RAW_W   = PNUM_W + 3 * CLK_W + 2 * SUM_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_RAW_W;

  // One stored process entry; the arrival time sits in the lowest bits.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] arrival;
  } entry_t;

  // Outcome of one pass over the entry memory.
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] min_arrival;
  } scan_res_t;

  // Control states of the scheduler.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_WAIT,
    ST_TALLY,
    ST_EMIT
  } state_e;

endpackage

// ===== design/nps_mem.sv =====
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module nps_mem #(
  parameter int unsigned DEPTH  = nps_pkg::MAX_PROCS_DEF,
  parameter int unsigned ADDR_W = 4
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [ADDR_W-1:0]  wr_addr_i,
  input  nps_pkg::entry_t    wr_data_i,
  input  logic               rd_en_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  output nps_pkg::entry_t    rd_data_o
);
  import nps_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  // Write port, used while entries are loaded.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/nps_scan.sv =====
// Scan unit: walks the entry memory and picks the ready entry of lowest priority value.
`timescale 1ns / 1ps
module nps_scan #(
  parameter int unsigned MAX_PROCS = nps_pkg::MAX_PROCS_DEF,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned CNT_W     = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [CNT_W-1:0]             count_i,
  input  logic [nps_pkg::CLK_W-1:0]    clock_i,
  input  logic [MAX_PROCS-1:0]         done_i,
  output logic                         rd_en_o,
  output logic [IDX_W-1:0]             rd_addr_o,
  input  nps_pkg::entry_t              rd_data_i,
  output logic                         scan_done_o,
  output logic [IDX_W-1:0]             best_idx_o,
  output nps_pkg::scan_res_t           res_o
);
  import nps_pkg::*;

  logic              active_q, active_d;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic              rv_q, rlast_q, fin_q;
  logic [IDX_W-1:0]  ridx_q;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [PRIO_W-1:0] best_pr_q, best_pr_d;
  logic [TIME_W-1:0] best_arr_q, best_arr_d;
  logic [TIME_W-1:0] best_burst_q, best_burst_d;
  logic [TIME_W-1:0] min_arr_q, min_arr_d;
  logic              is_last, pending, ready, take;

  // Address sequencing and running selection over the returned entries.
  always_comb begin
    is_last  = (CNT_W'(addr_q) + CNT_W'(1)) == count_i;
    pending  = rv_q && !done_i[ridx_q];
    ready    = pending && (CLK_W'(rd_data_i.arrival) <= clock_i);
    take     = ready && (!found_q || (rd_data_i.prio < best_pr_q));

    active_d     = active_q;
    addr_d       = addr_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_pr_d    = best_pr_q;
    best_arr_d   = best_arr_q;
    best_burst_d = best_burst_q;
    min_arr_d    = min_arr_q;

    if (start_i) begin
      active_d  = 1'b1;
      addr_d    = '0;
      found_d   = 1'b0;
      min_arr_d = '1;
    end else begin
      if (active_q) begin
        addr_d = addr_q + IDX_W'(1);
        if (is_last) begin
          active_d = 1'b0;
        end
      end
      if (take) begin
        found_d      = 1'b1;
        best_idx_d   = ridx_q;
        best_pr_d    = rd_data_i.prio;
        best_arr_d   = rd_data_i.arrival;
        best_burst_d = rd_data_i.burst;
      end
      if (pending && (rd_data_i.arrival < min_arr_q)) begin
        min_arr_d = rd_data_i.arrival;
      end
    end
  end

  // Control registers of the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rv_q     <= 1'b0;
      rlast_q  <= 1'b0;
      fin_q    <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      rv_q     <= active_q && !start_i;
      rlast_q  <= is_last;
      fin_q    <= rv_q && rlast_q && !start_i;
      found_q  <= found_d;
    end
  end

  // Address and selection payload.
  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    ridx_q       <= addr_q;
    best_idx_q   <= best_idx_d;
    best_pr_q    <= best_pr_d;
    best_arr_q   <= best_arr_d;
    best_burst_q <= best_burst_d;
    min_arr_q    <= min_arr_d;
  end

  assign rd_en_o             = active_q;
  assign rd_addr_o           = addr_q;
  assign scan_done_o         = fin_q;
  assign best_idx_o          = best_idx_q;
  assign res_o.found         = found_q;
  assign res_o.arrival       = best_arr_q;
  assign res_o.burst         = best_burst_q;
  assign res_o.min_arrival   = min_arr_q;

endmodule

// ===== design/nonpreemptive_priority_scheduler.sv =====
// Top level: loading, schedule control, tallies and the result output register.
// Loading accepts one input transaction per cycle; the input is held off while a schedule runs.
// Each choice is one pass over the N loaded entries through the entry memory read port,
// followed by the tally and emit states of the schedule arithmetic for each completed process.
// A pass that finds no arrived entry moves the clock to the earliest arrival and passes again.
// Reset clears all control state and done flags; the entry memory itself is not cleared.
`timescale 1ns / 1ps
module nonpreemptive_priority_scheduler #(
  parameter int unsigned MAX_PROCS = nps_pkg::MAX_PROCS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // arrival_time [15:0], burst_time [31:16], priority_req [39:32]
  input  logic [nps_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // process_number [6:0], completion_time [29:7], turnaround [52:30], waiting [75:53],
  // total_waiting [104:76], total_turnaround [133:105], zero padding [135:134]
  output logic [nps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // final_res
  output logic                              m_axis_tuser_o
);
  import nps_pkg::*;

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_PROCS);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     cmp_q, cmp_d;
  logic [CLK_W-1:0]     clock_q, clock_d;
  logic [SUM_W-1:0]     sum_w_q, sum_w_d;
  logic [SUM_W-1:0]     sum_t_q, sum_t_d;
  logic [MAX_PROCS-1:0] done_q, done_d;
  logic [IDX_W-1:0]     sel_idx_q, sel_idx_d;
  logic [TIME_W-1:0]    sel_arr_q, sel_arr_d;
  logic [CLK_W-1:0]     wt_q, wt_d;
  logic [CLK_W-1:0]     tat_q, tat_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;

  logic                 in_acc, wr_en, scan_start, scan_done, rd_en, out_free, is_final;
  logic [IDX_W-1:0]     rd_addr, best_idx;
  entry_t               rd_data;
  scan_res_t            scan_res;
  logic [PNUM_W-1:0]    pnum;

  nps_mem #(
    .DEPTH  (MAX_PROCS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[IDX_W-1:0]),
    .wr_data_i (entry_t'(s_axis_tdata_i)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  nps_scan #(
    .MAX_PROCS (MAX_PROCS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .count_i     (cnt_q),
    .clock_i     (clock_q),
    .done_i      (done_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .scan_done_o (scan_done),
    .best_idx_o  (best_idx),
    .res_o       (scan_res)
  );

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en           = in_acc && (cnt_q < CntMax);
  assign scan_start      = (state_q == ST_SCAN);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign pnum            = PNUM_W'(sel_idx_q) + PNUM_W'(1);
  assign is_final        = (cmp_q == cnt_q);

  // Next state, schedule arithmetic and output register loading.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmp_d       = cmp_q;
    clock_d     = clock_q;
    sum_w_d     = sum_w_q;
    sum_t_d     = sum_t_q;
    done_d      = done_q;
    sel_idx_d   = sel_idx_q;
    sel_arr_d   = sel_arr_q;
    wt_d        = wt_q;
    tat_d       = tat_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CntMax) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (s_axis_tlast_i) begin
            clock_d = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (scan_done) begin
          if (scan_res.found) begin
            // Waiting time is the start time less the arrival time.
            clock_d           = clock_q + CLK_W'(scan_res.burst);
            wt_d              = clock_q - CLK_W'(scan_res.arrival);
            sel_idx_d         = best_idx;
            sel_arr_d         = scan_res.arrival;
            done_d[best_idx]  = 1'b1;
            cmp_d             = cmp_q + CNT_W'(1);
            state_d           = ST_TALLY;
          end else begin
            // Nothing has arrived: jump to the earliest pending arrival.
            clock_d = CLK_W'(scan_res.min_arrival);
            state_d = ST_SCAN;
          end
        end
      end
      ST_TALLY: begin
        tat_d   = clock_q - CLK_W'(sel_arr_q);
        sum_w_d = sum_w_q + SUM_W'(wt_q);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          sum_t_d     = sum_t_q + SUM_W'(tat_q);
          out_valid_d = 1'b1;
          out_data_d  = {{OUT_PAD_W{1'b0}}, sum_t_d, sum_w_q, wt_q, tat_q, clock_q, pnum};
          out_last_d  = is_final;
          if (is_final) begin
            cnt_d   = '0;
            cmp_d   = '0;
            clock_d = '0;
            sum_w_d = '0;
            sum_t_d = '0;
            done_d  = '0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      cmp_q       <= '0;
      clock_q     <= '0;
      sum_w_q     <= '0;
      sum_t_q     <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cmp_q       <= cmp_d;
      clock_q     <= clock_d;
      sum_w_q     <= sum_w_d;
      sum_t_q     <= sum_t_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sel_idx_q  <= sel_idx_d;
    sel_arr_q  <= sel_arr_d;
    wt_q       <= wt_d;
    tat_q      <= tat_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_last_q;

  // A pass only completes while the controller is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> (state_q == ST_WAIT))
    else $error("scan finished outside the wait state");

  // Completed processes never outnumber the loaded entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_q <= cnt_q)
    else $error("completion count exceeds entry count");

  // A chosen entry has not run yet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) && scan_done && scan_res.found |-> !done_q[best_idx])
    else $error("completed entry chosen again");

  // An empty pass always leaves a later arrival to jump to.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) && scan_done && !scan_res.found
      |-> (CLK_W'(scan_res.min_arrival) > clock_q))
    else $error("idle jump does not move the clock forward");

  // A schedule never runs over an empty load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (cnt_q != '0))
    else $error("schedule running with no entries");

endmodule

// ===== tb/sv/nonpreemptive_priority_scheduler_test.sv =====
// Self-checking testbench for the non-preemptive priority scheduler.
`timescale 1ns / 1ps
module nonpreemptive_priority_scheduler_test;
  import nps_pkg::*;

  localparam int unsigned SLOTS        = MAX_PROCS_DEF;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 120;
  localparam int unsigned HOLD_AFTER   = 120;
  localparam int unsigned HOLD_CYCLES  = 400;

  // Result layout as it travels on the master tdata, last field in the lowest bits.
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [SUM_W-1:0]     sum_tat;
    logic [SUM_W-1:0]     sum_wt;
    logic [CLK_W-1:0]     wt;
    logic [CLK_W-1:0]     tat;
    logic [CLK_W-1:0]     done_at;
    logic [PNUM_W-1:0]    pnum;
  } completion_t;

  // Keeps the loaded process set, works out the schedule and checks each completion.
  class completion_ledger;
    entry_t      slots[SLOTS];
    int unsigned n_loaded;
    int unsigned accepted;
    int unsigned fail_count;
    completion_t due_completions[$];
    logic        due_last[$];

    function new();
      n_loaded   = 0;
      accepted   = 0;
      fail_count = 0;
    endfunction

    function int unsigned pending();
      return due_completions.size();
    endfunction

    // Plays the whole schedule over the loaded entries and queues the completions.
    function void run_schedule();
      bit          done_flag[SLOTS];
      int unsigned now;
      int unsigned sum_w;
      int unsigned sum_t;
      int unsigned finished;
      int unsigned earliest;
      int unsigned tat;
      int unsigned wt;
      int          pick;
      completion_t c;
      now      = 0;
      sum_w    = 0;
      sum_t    = 0;
      finished = 0;
      foreach (done_flag[i]) done_flag[i] = 1'b0;
      while (finished < n_loaded) begin
        pick = -1;
        for (int i = 0; i < n_loaded; i++) begin
          if (!done_flag[i] && slots[i].arrival <= now) begin
            if (pick < 0 || slots[i].prio < slots[pick].prio) pick = i;
          end
        end
        // Nothing has arrived yet: the clock moves on to the earliest pending arrival.
        if (pick < 0) begin
          earliest = 32'hFFFF_FFFF;
          for (int i = 0; i < n_loaded; i++) begin
            if (!done_flag[i] && slots[i].arrival < earliest) earliest = slots[i].arrival;
          end
          now = earliest;
          continue;
        end
        now = now + slots[pick].burst;
        tat = now - slots[pick].arrival;
        wt  = tat - slots[pick].burst;
        done_flag[pick] = 1'b1;
        finished++;
        sum_w = sum_w + wt;
        sum_t = sum_t + tat;
        c = '0;
        c.pnum    = PNUM_W'(pick + 1);
        c.done_at = CLK_W'(now);
        c.tat     = CLK_W'(tat);
        c.wt      = CLK_W'(wt);
        c.sum_wt  = SUM_W'(sum_w);
        c.sum_tat = SUM_W'(sum_t);
        due_completions.push_back(c);
        due_last.push_back(finished == n_loaded);
      end
      n_loaded = 0;
    endfunction

    // Notes one accepted input transaction; entries beyond capacity are dropped.
    function void load_entry(entry_t e, logic last);
      accepted++;
      if (n_loaded < SLOTS) begin
        slots[n_loaded] = e;
        n_loaded++;
      end
      if (last) run_schedule();
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    // Compares one output transaction with the oldest expected completion.
    function void check_completion(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
      completion_t act;
      completion_t exp_c;
      logic        exp_last;
      act = completion_t'(tdata);
      if (due_completions.size() == 0) begin
        $error("completion of process %0d with none expected", act.pnum);
        fail_count++;
        return;
      end
      exp_c    = due_completions.pop_front();
      exp_last = due_last.pop_front();
      compare_field("process_number", exp_c.pnum, act.pnum);
      compare_field("completion_time", exp_c.done_at, act.done_at);
      compare_field("turnaround", exp_c.tat, act.tat);
      compare_field("waiting", exp_c.wt, act.wt);
      compare_field("total_waiting", exp_c.sum_wt, act.sum_wt);
      compare_field("total_turnaround", exp_c.sum_tat, act.sum_tat);
      compare_field("final_res", exp_last, tuser);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   s_axis_tlast_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  completion_ledger ledger;
  logic             quiet_stretch;
  logic             held_off;
  int unsigned      cycle_count;
  int unsigned      random_sent;

  nonpreemptive_priority_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Clock with a 4 ns period.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run guard: a stuck handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Every output transaction is checked at the rising edge on which it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      ledger.check_completion(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Receiver: random back-pressure, one long hold-off once, none in the quiet stretch.
  initial begin
    m_axis_tready_i = 1'b0;
    held_off        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_off && ledger != null && ledger.accepted >= HOLD_AFTER) begin
        held_off        = 1'b1;
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (quiet_stretch) begin
        m_axis_tready_i = 1'b1;
      end else begin
        m_axis_tready_i = ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Offers one process entry, with a random gap in front, and waits for the transaction.
  task automatic send_entry(input entry_t e, input logic last);
    if (!quiet_stretch && $urandom_range(0, 99) < 25) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk_i);
        s_axis_tvalid_i = 1'b0;
        @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = e;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    ledger.load_entry(e, last);
  endtask

  task automatic send_fields(input int unsigned arr, input int unsigned burst,
                             input int unsigned prio, input logic last);
    entry_t e;
    e.arrival = TIME_W'(arr);
    e.burst   = TIME_W'(burst);
    e.prio    = PRIO_W'(prio);
    send_entry(e, last);
  endtask

  // Holds the sender off until every expected completion has been seen.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  // One process set with random content; the style picks contention, wide or full-range values.
  task automatic send_random_set(input int unsigned n);
    int unsigned style;
    int unsigned arr;
    int unsigned burst;
    int unsigned prio;
    style = $urandom_range(0, 9);
    for (int unsigned i = 0; i < n; i++) begin
      if (style < 6) begin
        arr   = $urandom_range(0, 40);
        burst = $urandom_range(0, 12);
        prio  = $urandom_range(0, 3);
      end else if (style < 8) begin
        arr   = $urandom_range(0, 2000);
        burst = $urandom_range(0, 500);
        prio  = $urandom_range(0, 255);
      end else begin
        arr   = $urandom_range(0, 65535);
        burst = $urandom_range(0, 65535);
        prio  = $urandom_range(0, 255);
      end
      send_fields(arr, burst, prio, i == n - 1);
      random_sent++;
    end
  endtask

  // Main sequence: reset, directed sets, random sets, drain and verdict.
  initial begin
    int unsigned set_idx;
    int unsigned n;
    ledger          = new();
    quiet_stretch   = 1'b0;
    random_sent     = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    rst_ni          = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // A lone process with all fields at zero: a zero burst completes at once.
    send_fields(0, 0, 0, 1'b1);
    // A lone process with every field at its maximum: the clock jumps to its arrival.
    send_fields(65535, 65535, 255, 1'b1);
    // Equal priorities at the same arrival, an idle start and a late arrival.
    send_fields(7, 0, 2, 1'b0);
    send_fields(7, 3, 2, 1'b0);
    send_fields(2, 4, 9, 1'b0);
    send_fields(60, 1, 0, 1'b1);
    // More entries than the block can hold; the marked last one falls beyond capacity.
    for (int unsigned i = 0; i < SLOTS + 2; i++) begin
      send_fields(i * 3, i % 4, (i * 5) % 7, i == SLOTS + 1);
    end
    wait_drained();

    set_idx = 0;
    while (random_sent < RANDOM_ITEMS) begin
      quiet_stretch = (set_idx >= 10 && set_idx < 16);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(SLOTS + 1, SLOTS + 4);
      else n = $urandom_range(1, SLOTS);
      send_random_set(n);
      if (set_idx == 20) wait_drained();
      set_idx++;
    end
    quiet_stretch = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (ledger.fail_count == 0 && ledger.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
